// ----- rtl/tcfs_pkg.sv -----
`default_nettype none

package tcfs_pkg;

    localparam int PREFIX_BYTES = 63;
    localparam int PREFIX_AW    = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
    localparam int PREFIX_CW    = $clog2(PREFIX_BYTES + 1);

    localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
    localparam logic [7:0] DELIM_RESET    = 8'h09;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] START_RESET    = 8'd1;
    localparam logic [7:0] END_RESET      = 8'd0;

    localparam int         CFG_AW         = 4;
    localparam logic [1:0] REG_FIELD_MODE = 2'd0;
    localparam logic [1:0] REG_DELIMITER  = 2'd1;
    localparam logic [1:0] REG_START      = 2'd2;
    localparam logic [1:0] REG_END        = 2'd3;

    typedef struct packed {
        logic       field_mode;
        logic [7:0] delimiter;
        logic [7:0] range_start;
        logic [7:0] range_end;
    } tcfs_cfg_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH_RD,
        ST_FLUSH_EMIT,
        ST_FLUSH_NL
    } tcfs_state_t;

    typedef struct packed {
        logic accept;
        logic flush_rd;
        logic flush_emit;
        logic flush_nl;
    } tcfs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_flush;
        logic flush_last;
    } tcfs_status_t;

    function automatic logic in_range(input logic [7:0] k, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (k >= lo) && ((hi == 8'd0) || (k <= hi));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/text_column_field_selector.sv -----
// Channel   Dir  Signals                            Contents
// s_axis    in   tvalid tready tdata[7:0]           in_byte
// m_axis    out  tvalid tready tdata[7:0] tlast     out_byte, last_of_run
//                tuser[0]                           prefix_overflow
// apb       in   psel penable pwrite paddr pwdata   field_mode, delimiter,
//                prdata pready                      range_start, range_end
//
// One input item per cycle while the output drains and no flush runs; zero or one
// result each, except a newline ending a line short of the first selected field,
// draining the prefix RAM (registered read, then emit, per byte), then the newline.
// rst_n clears line counters, output valid and registers to their defaults.
// m_axis_tready low stalls the output register and, through it, s_axis_tready.
`default_nettype none

module text_column_field_selector
    import tcfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [7:0]        m_axis_tdata,   // [7:0] out_byte
    output logic                   m_axis_tlast,
    output logic      [0:0]        m_axis_tuser,   // [0] prefix_overflow
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    tcfs_cfg_t    cfg;
    tcfs_cmd_t    cmd;
    tcfs_status_t status;

    tcfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcfs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    tcfs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

// ----- rtl/tcfs_ram.sv -----
`default_nettype none

module tcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/tcfs_regs.sv -----
`default_nettype none

module tcfs_regs
    import tcfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output tcfs_cfg_t              cfg
);

    tcfs_cfg_t  cfg_reg;
    tcfs_cfg_t  cfg_next;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_FIELD_MODE: cfg_next.field_mode  = pwdata[0];
                REG_DELIMITER:  cfg_next.delimiter   = pwdata[7:0];
                REG_START:      cfg_next.range_start = pwdata[7:0];
                REG_END:        cfg_next.range_end   = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FIELD_MODE: prdata = {31'd0, cfg_reg.field_mode};
            REG_DELIMITER:  prdata = {24'd0, cfg_reg.delimiter};
            REG_START:      prdata = {24'd0, cfg_reg.range_start};
            REG_END:        prdata = {24'd0, cfg_reg.range_end};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_mode  <= 1'b0;
            cfg_reg.delimiter   <= DELIM_RESET;
            cfg_reg.range_start <= START_RESET;
            cfg_reg.range_end   <= END_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcfs_ctrl.sv -----
`default_nettype none

module tcfs_ctrl
    import tcfs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire tcfs_status_t status,
    output tcfs_cmd_t    cmd
);

    tcfs_state_t state_reg;
    tcfs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                s_ready    = status.out_free;
                cmd.accept = s_valid && status.out_free;
                if (cmd.accept && status.need_flush)
                begin
                    state_next = ST_FLUSH_RD;
                end
            end
            ST_FLUSH_RD:
            begin
                cmd.flush_rd = 1'b1;
                state_next   = ST_FLUSH_EMIT;
            end
            ST_FLUSH_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    state_next     = status.flush_last ? ST_FLUSH_NL : ST_FLUSH_RD;
                end
            end
            ST_FLUSH_NL:
            begin
                if (status.out_free)
                begin
                    cmd.flush_nl = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // no input taken while a buffered line drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !s_ready)
        else $error("input ready during flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH_RD) |=> (state_reg == ST_FLUSH_EMIT))
        else $error("read not followed by emit");

endmodule

`default_nettype wire

// ----- rtl/tcfs_dp.sv -----
`default_nettype none

module tcfs_dp
    import tcfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire tcfs_cfg_t cfg,
    input  wire logic [7:0] in_byte,
    input  wire tcfs_cmd_t cmd,
    output tcfs_status_t status,
    input  wire logic    out_ready,
    output logic         out_valid,
    output logic [7:0]   out_byte,
    output logic         out_last,
    output logic         out_ovf
);

    logic [7:0]           char_pos_reg, char_pos_next;
    logic [7:0]           field_idx_reg, field_idx_next;
    logic [PREFIX_CW-1:0] prefix_cnt_reg, prefix_cnt_next;
    logic                 ovf_seen_reg, ovf_seen_next;
    logic [PREFIX_AW-1:0] rd_idx_reg, rd_idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic [7:0]           lo;
    logic [7:0]           char_pos_inc;
    logic [7:0]           field_idx_sat;
    logic [7:0]           field_idx_inc;
    logic                 is_nl;
    logic                 is_delim;
    logic                 before_lo;
    logic                 load;
    logic                 ram_we;
    logic [7:0]           ram_rdata;

    assign lo            = (cfg.range_start == 8'd0) ? 8'd1 : cfg.range_start;
    assign char_pos_inc  = (char_pos_reg == COUNT_MAX) ? char_pos_reg : char_pos_reg + 8'd1;
    assign field_idx_sat = (field_idx_reg == COUNT_MAX) ? field_idx_reg
                                                        : field_idx_reg + 8'd1;
    assign field_idx_inc = field_idx_reg + 8'd1;
    assign is_nl         = (in_byte == NEWLINE_BYTE);
    assign is_delim      = (in_byte == cfg.delimiter);
    assign before_lo     = (field_idx_reg < lo);

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.need_flush = is_nl && cfg.field_mode && before_lo
                               && (prefix_cnt_reg != '0);
    assign status.flush_last = (PREFIX_CW'(rd_idx_reg) + PREFIX_CW'(1)) == prefix_cnt_reg;

    tcfs_ram #(
        .WIDTH (8),
        .DEPTH (PREFIX_BYTES)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (PREFIX_AW'(prefix_cnt_reg)),
        .wdata (in_byte),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        char_pos_next   = char_pos_reg;
        field_idx_next  = field_idx_reg;
        prefix_cnt_next = prefix_cnt_reg;
        ovf_seen_next   = ovf_seen_reg;
        rd_idx_next     = rd_idx_reg;
        ram_we          = 1'b0;
        load            = 1'b0;
        out_byte_next   = in_byte;
        out_last_next   = 1'b1;
        out_ovf_next    = ovf_seen_reg;

        priority if (cmd.accept)
        begin
            rd_idx_next = '0;
            priority if (is_nl)
            begin
                if (!status.need_flush)
                begin
                    load            = 1'b1;
                    out_byte_next   = NEWLINE_BYTE;
                    char_pos_next   = 8'd0;
                    field_idx_next  = 8'd1;
                    prefix_cnt_next = '0;
                    ovf_seen_next   = 1'b0;
                end
            end
            else if (!cfg.field_mode)
            begin
                char_pos_next = char_pos_inc;
                load          = in_range(char_pos_inc, lo, cfg.range_end);
            end
            else if (before_lo)
            begin
                if (prefix_cnt_reg < PREFIX_CW'(PREFIX_BYTES))
                begin
                    ram_we          = 1'b1;
                    prefix_cnt_next = prefix_cnt_reg + PREFIX_CW'(1);
                end
                else
                begin
                    ovf_seen_next = 1'b1;
                end
                if (is_delim)
                begin
                    field_idx_next = field_idx_inc;
                    if (field_idx_inc >= lo)
                    begin
                        prefix_cnt_next = '0;
                    end
                end
            end
            else if (is_delim)
            begin
                // delimiter kept only between two selected fields
                load = in_range(field_idx_reg, lo, cfg.range_end)
                       && ((cfg.range_end == 8'd0) || (field_idx_reg < cfg.range_end));
                field_idx_next = field_idx_sat;
            end
            else
            begin
                load = in_range(field_idx_reg, lo, cfg.range_end);
            end
        end
        else if (cmd.flush_emit)
        begin
            load          = 1'b1;
            out_byte_next = ram_rdata;
            out_last_next = 1'b0;
            rd_idx_next   = rd_idx_reg + PREFIX_AW'(1);
        end
        else if (cmd.flush_nl)
        begin
            load            = 1'b1;
            out_byte_next   = NEWLINE_BYTE;
            char_pos_next   = 8'd0;
            field_idx_next  = 8'd1;
            prefix_cnt_next = '0;
            ovf_seen_next   = 1'b0;
        end
        else
        begin
            load = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg   <= 8'd0;
            field_idx_reg  <= 8'd1;
            prefix_cnt_reg <= '0;
            ovf_seen_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            char_pos_reg   <= char_pos_next;
            field_idx_reg  <= field_idx_next;
            prefix_cnt_reg <= prefix_cnt_next;
            ovf_seen_reg   <= ovf_seen_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        prefix_cnt_reg <= PREFIX_CW'(PREFIX_BYTES))
        else $error("prefix count past buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_rd |-> (PREFIX_CW'(rd_idx_reg) < prefix_cnt_reg))
        else $error("flush read beyond buffered prefix");

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept || cmd.flush_emit || cmd.flush_nl) |-> status.out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

// ----- tb/tcfs_checker.sv -----
`default_nettype none

module tcfs_checker
    import tcfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [7:0]        m_axis_tdata,
    input  wire logic              m_axis_tlast,
    input  wire logic [0:0]        m_axis_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    output int                     mismatches,
    output int                     pending_bytes
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } cut_byte_t;

    tcfs_cfg_t   cfg;
    logic [7:0]  char_pos;
    logic [7:0]  field_idx;
    logic [7:0]  prefix_mem [0:PREFIX_BYTES-1];
    logic [5:0]  prefix_cnt;
    logic        ovf_seen;
    cut_byte_t   selected_q [$];

    function automatic logic within_span(input logic [7:0] k, input logic [7:0] lo,
                                         input logic [7:0] hi);
        return (k >= lo) && ((hi == 8'd0) || (k <= hi));
    endfunction

    function automatic cut_byte_t out_beat(input logic [7:0] d, input logic o);
        cut_byte_t r;
        r.data = d;
        r.last = 1'b0;
        r.ovf  = o;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < 30)
            $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic clear_line();
        char_pos   = 8'd0;
        field_idx  = 8'd1;
        prefix_cnt = 6'd0;
        ovf_seen   = 1'b0;
    endtask

    task automatic select_bytes(input logic [7:0] b);
        logic [7:0] lo;
        int         n0;
        cut_byte_t  tail;
        lo = (cfg.range_start == 8'd0) ? 8'd1 : cfg.range_start;
        n0 = selected_q.size();
        if (b == NEWLINE_BYTE)
        begin
            if (cfg.field_mode && field_idx < lo)
                for (int k = 0; k < prefix_cnt; k++)
                    selected_q.push_back(out_beat(prefix_mem[k], ovf_seen));
            selected_q.push_back(out_beat(NEWLINE_BYTE, ovf_seen));
            clear_line();
        end
        else if (!cfg.field_mode)
        begin
            if (char_pos != COUNT_MAX)
                char_pos++;
            if (within_span(char_pos, lo, cfg.range_end))
                selected_q.push_back(out_beat(b, ovf_seen));
        end
        else if (field_idx < lo)
        begin
            if (prefix_cnt < PREFIX_BYTES)
            begin
                prefix_mem[prefix_cnt] = b;
                prefix_cnt++;
            end
            else
                ovf_seen = 1'b1;
            if (b == cfg.delimiter)
            begin
                field_idx++;
                if (field_idx >= lo)
                    prefix_cnt = 6'd0;
            end
        end
        else if (b == cfg.delimiter)
        begin
            if (within_span(field_idx, lo, cfg.range_end) &&
                (cfg.range_end == 8'd0 || field_idx < cfg.range_end))
                selected_q.push_back(out_beat(b, ovf_seen));
            if (field_idx != COUNT_MAX)
                field_idx++;
        end
        else if (within_span(field_idx, lo, cfg.range_end))
            selected_q.push_back(out_beat(b, ovf_seen));
        if (selected_q.size() > n0)
        begin
            tail = selected_q.pop_back();
            tail.last = 1'b1;
            selected_q.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cut_byte_t want;
        if (!rst_n)
        begin
            cfg.field_mode  = 1'b0;
            cfg.delimiter   = DELIM_RESET;
            cfg.range_start = START_RESET;
            cfg.range_end   = END_RESET;
            clear_line();
            selected_q.delete();
            mismatches    = 0;
            pending_bytes = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (selected_q.size() == 0)
                    report_mismatch("unexpected item, data", m_axis_tdata, 8'h00);
                else
                begin
                    want = selected_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch("out_byte", m_axis_tdata, want.data);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", {7'd0, m_axis_tlast}, {7'd0, want.last});
                    if (m_axis_tuser[0] !== want.ovf)
                        report_mismatch("prefix_overflow", {7'd0, m_axis_tuser[0]},
                                        {7'd0, want.ovf});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                select_bytes(s_axis_tdata);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FIELD_MODE: cfg.field_mode  = pwdata[0];
                    REG_DELIMITER:  cfg.delimiter   = pwdata[7:0];
                    REG_START:      cfg.range_start = pwdata[7:0];
                    REG_END:        cfg.range_end   = pwdata[7:0];
                    default: ;
                endcase
            end
            pending_bytes = selected_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    import tcfs_pkg::*;

    localparam logic [7:0] COMMA      = 8'h2C;
    localparam int         CYCLE_MAX  = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    wire logic         s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;
    wire logic         m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    wire logic [7:0]   m_axis_tdata;
    wire logic         m_axis_tlast;
    wire logic [0:0]   m_axis_tuser;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = 32'd0;
    wire logic [31:0]  prdata;
    wire logic         pready;

    int                mismatches;
    int                pending_bytes;
    int                snd_idle = 24;
    int                rcv_idle = 69;
    int                items_sent = 0;
    int                cycles = 0;
    logic              cur_mode = 1'b0;
    logic [7:0]        cur_delim = DELIM_RESET;

    text_column_field_selector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tcfs_checker cut_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .pending_bytes (pending_bytes)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_MAX)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_config(input logic mode, input logic [7:0] delim,
                                input logic [7:0] lo, input logic [7:0] hi);
        apb_write(REG_FIELD_MODE, {7'd0, mode});
        apb_write(REG_DELIMITER, delim);
        apb_write(REG_START, lo);
        apb_write(REG_END, hi);
        cur_mode  = mode;
        cur_delim = delim;
    endtask

    task automatic rand_config();
        logic       mode;
        logic [7:0] delim;
        logic [7:0] lo;
        logic [7:0] hi;
        int         pick;
        mode = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            delim = COMMA;
        else if (pick < 7)
            delim = DELIM_RESET;
        else if (pick == 7)
            delim = NEWLINE_BYTE;
        else if (pick == 8)
            delim = 8'($urandom_range(0, 255));
        else
            delim = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            lo = 8'd0;
        else if (pick == 1)
            lo = COUNT_MAX;
        else if (pick < 4)
            lo = 8'd1;
        else
            lo = 8'($urandom_range(2, 6));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            hi = 8'd0;
        else if (pick == 3)
            hi = COUNT_MAX;
        else if (pick == 4)
            hi = lo - 8'd1;
        else if (pick == 5)
            hi = lo;
        else
            hi = lo + 8'($urandom_range(0, 4));
        write_config(mode, delim, lo, hi);
    endtask

    task automatic send_line(input int len, input int delim_pct);
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < delim_pct)
                send_byte(cur_delim);
            else if (r < delim_pct + 8)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
    endtask

    initial
    begin
        int mode_items;
        int nlines;
        int len;
        int pct;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(NEWLINE_BYTE);
        drain();
        write_config(1'b0, DELIM_RESET, 8'd0, 8'd2);
        send_text("123\n");
        drain();
        write_config(1'b0, DELIM_RESET, 8'd5, 8'd3);
        send_text("ab\n");
        drain();
        write_config(1'b1, NEWLINE_BYTE, 8'd2, 8'd0);
        send_text("x\n");
        drain();
        write_config(1'b1, COMMA, 8'd2, 8'd3);
        send_text("a,b,c,d\n");
        drain();
        write_config(1'b1, COMMA, 8'd3, 8'd0);
        send_text("a,b\n");
        drain();
        write_config(1'b1, COMMA, 8'd3, 8'd2);
        send_text("a,b,c\n");

        for (int m = 0; m < 3; m++)
        begin
            drain();
            snd_idle = (m == 0) ? 24 : (m == 1) ? 69 : 0;
            rcv_idle = (m == 0) ? 69 : (m == 1) ? 24 : 0;

            // short line whose prefix overflows the buffer
            if (m == 0)
            begin
                write_config(1'b1, COMMA, 8'd200, 8'd0);
                send_line($urandom_range(66, 72), 5);
                send_byte(NEWLINE_BYTE);
            end

            mode_items = items_sent;
            while (items_sent - mode_items < 30)
            begin
                drain();
                rand_config();
                nlines = $urandom_range(1, 4);
                for (int l = 0; l < nlines; l++)
                begin
                    pct = $urandom_range(0, 99);
                    if (pct < 80)
                        len = $urandom_range(0, 12);
                    else if (pct < 95)
                        len = $urandom_range(13, 40);
                    else
                        len = $urandom_range(60, 90);
                    send_line(len, cur_mode ? $urandom_range(10, 40) : 10);
                    // occasionally leave a line open across a register change
                    if (l != nlines - 1 || $urandom_range(0, 4) != 0)
                        send_byte(NEWLINE_BYTE);
                end
            end
        end

        drain();
        if (mismatches == 0 && pending_bytes == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
